[sv/error_function_approx_defines.svh]
// Assertion macros shared by the error function block
`ifndef ERROR_FUNCTION_APPROX_DEFINES_SVH
`define ERROR_FUNCTION_APPROX_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a condition at every clock edge out of reset
`define EFA_ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("error function block: check failed");
// Check that a condition implies another one on the next edge
`define EFA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("error function block: check failed");
`else
`define EFA_ASSERT_ALWAYS(name, expr)
`define EFA_ASSERT_NEXT(name, ante, cons)
`endif
`endif

[sv/erfa_pkg.sv]
`default_nettype none

package erfa_pkg;

  localparam int IN_WIDTH_DEF  = 16;
  localparam int OUT_WIDTH_DEF = 16;

  // Unsigned Q.30 value up to one, divisor of the reciprocal, signed accumulator
  typedef logic [30:0]        q30_t;
  typedef logic [31:0]        den_t;
  typedef logic signed [32:0] acc_t;

  localparam q30_t ONE_Q30 = q30_t'(1) << 30;

  // Approximation constants in fixed point
  localparam logic [28:0] COEF_P    = 29'd351748265;    // Q.30
  localparam acc_t        COEF_A1   = 33'sd273621191;   // Q.30
  localparam acc_t        COEF_A2   = -33'sd305476044;
  localparam acc_t        COEF_A3   = 33'sd1526231383;
  localparam acc_t        COEF_A4   = -33'sd1560310108;
  localparam acc_t        COEF_A5   = 33'sd1139675401;
  localparam logic [28:0] LOG2E_Q28 = 29'd387270501;    // Q.28
  localparam logic [29:0] LN2_Q30   = 30'd744261118;    // Q.30

  // Horner steps: multiply by t, then add the next coefficient (none on the last)
  localparam int   HORNER_STEPS = 5;
  localparam acc_t COEF_ADD [1:HORNER_STEPS] = '{COEF_A4, COEF_A3, COEF_A2, COEF_A1, 33'sd0};

  // Taylor terms of exp(-r) and floor(2^32 / k) for the divide by k
  localparam int          TERMS = 14;
  localparam logic [32:0] RECIP_K [1:TERMS] = '{
    33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
    33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912,
    33'd477218588,  33'd429496729,  33'd390451572,  33'd357913941,
    33'd330382099,  33'd306783378
  };

  // exp(-x^2) is zero from this power of two on
  localparam logic [6:0] EXP_ZERO_N = 7'd40;

  // Start remainder of 2^60 / den: the dividend bits above bit 30
  localparam den_t DIV_REM_INIT = den_t'(1) << 29;

  // Stage counts
  localparam int DIV_LAT    = 31;                     // one quotient bit per stage
  localparam int HORNER_LAT = 2 * HORNER_STEPS;       // multiply, then round and add
  localparam int EXP_LAT    = 3 * TERMS + 3;          // u, r, three per term, shift
  localparam int ALIGN_LAT  = EXP_LAT - DIV_LAT - HORNER_LAT;
  localparam int FRONT_LAT  = 3;
  localparam int BACK_LAT   = 2;
  localparam int PIPE_LAT   = FRONT_LAT + EXP_LAT + BACK_LAT;

endpackage

`default_nettype wire

[sv/erfa_x_if.sv]
`default_nettype none

interface erfa_x_if
  import erfa_pkg::*;
#(
  parameter int W = IN_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] x_in;

  modport source (output valid, output x_in, input ready);
  modport sink   (input valid, input x_in, output ready);
endinterface

`default_nettype wire

[sv/erfa_erf_if.sv]
`default_nettype none

interface erfa_erf_if
  import erfa_pkg::*;
#(
  parameter int W = OUT_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] erf_out;

  modport source (output valid, output erf_out, input ready);
  modport sink   (input valid, input erf_out, output ready);
endinterface

`default_nettype wire

[sv/erfa_div.sv]
`default_nettype none

// Pipelined restoring divider: t = round(2^60 / den), one quotient bit per stage
module erfa_div
  import erfa_pkg::*;
(
  input  wire logic clk,
  input  wire logic en,
  input  wire den_t den_i,
  output q30_t      t_o
);

  den_t rem_r [DIV_LAT];
  den_t den_r [DIV_LAT];
  q30_t quo_r [DIV_LAT];

  for (genvar i = 0; i < DIV_LAT; i++) begin : g_bit
    localparam int J = DIV_LAT - 1 - i;
    den_t        rem_in;
    den_t        den_in;
    q30_t        quo_in;
    logic [32:0] cand;
    logic        ge;

    if (i == 0) begin : g_first
      assign rem_in = DIV_REM_INIT;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign quo_in = quo_r[i-1];
    end

    // Bring down the next dividend bit (the low dividend bits are den >> 1)
    assign cand = {rem_in, den_in[J+1]};
    assign ge   = cand >= {1'b0, den_in};

    // Subtract when it fits and set the quotient bit
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? 32'(cand - {1'b0, den_in}) : cand[31:0];
        den_r[i] <= den_in;
        quo_r[i] <= quo_in | (q30_t'(ge) << J);
      end
    end
  end

  assign t_o = quo_r[DIV_LAT-1];

endmodule

`default_nettype wire

[sv/erfa_exp.sv]
`default_nettype none

// Pipelined exp(-x^2): range reduction by powers of two and a Taylor sum
module erfa_exp
  import erfa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [32:0] sq_i,   // x^2 in Q.28, below 32
  input  wire logic        big_i,  // x^2 at 32 or above
  output q30_t             e_o
);

  typedef struct packed {
    logic [29:0]        r;
    logic [6:0]         n;
    logic               zero;
    logic signed [31:0] sum;
  } side_t;

  logic [34:0] u_r;
  logic        big_r;
  logic [61:0] u_prod;
  logic [57:0] r_prod;
  logic [6:0]  n_w;
  side_t       side0_r;

  logic [60:0] prod_r [1:TERMS];
  side_t       sa_r   [1:TERMS];
  q30_t        quo_r  [1:TERMS];
  logic [63:0] pm_r   [1:TERMS];
  side_t       sb_r   [1:TERMS];
  q30_t        term_r [1:TERMS];
  side_t       sc_r   [1:TERMS];
  q30_t        e_r;

  // Scale to base two: u = x^2 * log2(e)
  assign u_prod = sq_i * LOG2E_Q28;

  always_ff @(posedge clk) begin
    if (en) begin
      u_r   <= 35'((64'(u_prod) + (64'd1 << 27)) >> 28);
      big_r <= big_i;
    end
  end

  // Split u into integer n and fraction, r = frac * ln2
  assign n_w    = u_r[34:28];
  assign r_prod = u_r[27:0] * LN2_Q30;

  always_ff @(posedge clk) begin
    if (en) begin
      side0_r.r    <= 30'((r_prod + 58'(64'd1 << 27)) >> 28);
      side0_r.n    <= n_w;
      side0_r.zero <= big_r || (n_w >= EXP_ZERO_N);
      side0_r.sum  <= 32'sd1073741824;
    end
  end

  // One Taylor term in three stages: multiply, divide by k, correct and add
  for (genvar k = 1; k <= TERMS; k++) begin : g_term
    localparam bit          ODD = (k % 2) == 1;
    localparam logic [60:0] RND = 61'(k) << 29;
    q30_t        term_in;
    side_t       side_in;
    q30_t        q_est;
    logic [34:0] q_back;
    logic [34:0] q_rem;
    logic        q_under;
    q30_t        term_nxt;
    side_t       sc_nxt;

    if (k == 1) begin : g_first
      assign term_in = ONE_Q30;
      assign side_in = side0_r;
    end else begin : g_next
      assign term_in = term_r[k-1];
      assign side_in = sc_r[k-1];
    end

    assign q_est    = 31'(pm_r[k] >> 32);
    assign q_back   = 35'(q_est) * 35'(k);
    assign q_rem    = 35'(quo_r[k]) - q_back;
    assign q_under  = q_rem >= 35'(k);
    assign term_nxt = q_under ? q_est + 31'd1 : q_est;

    // Add or subtract the corrected term
    always_comb begin
      sc_nxt     = sb_r[k];
      sc_nxt.sum = ODD ? sb_r[k].sum - $signed({1'b0, term_nxt})
                       : sb_r[k].sum + $signed({1'b0, term_nxt});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        prod_r[k] <= 61'(term_in) * 61'(side_in.r);
        sa_r[k]   <= side_in;
        quo_r[k]  <= 31'((prod_r[k] + RND) >> 30);
        pm_r[k]   <= 64'(31'((prod_r[k] + RND) >> 30)) * 64'(RECIP_K[k]);
        sb_r[k]   <= sa_r[k];
        term_r[k] <= term_nxt;
        sc_r[k]   <= sc_nxt;
      end
    end
  end

  // Shift down by n with half-up rounding, or drop to zero
  always_ff @(posedge clk) begin
    if (en) begin
      if (sc_r[TERMS].zero) begin
        e_r <= '0;
      end else begin
        e_r <= 31'(((33'({sc_r[TERMS].sum, 1'b0}) >> sc_r[TERMS].n) + 33'd1) >> 1);
      end
    end
  end

  assign e_o = e_r;

endmodule

`default_nettype wire

[sv/error_function_approx.sv]
// Channel   Interface     Direction  Payload
// in_x      erfa_x_if     sink       x_in     signed Q4.(IN_WIDTH-4)
// out_erf   erfa_erf_if   source     erf_out  signed Q1.(OUT_WIDTH-1)
//
// One item enters per cycle while the output buffer has room. The depth comes
// from front and back stages around two paths that run side by side: the 31
// one-bit divider stages and the 45 exp stages (u, r, three per term, shift).
// Reset clears the stage valid bits and the output buffer count; data needs none.
// A two-entry output buffer holds results; the whole pipeline halts only while
// both entries are full, so nothing is dropped or repeated under a stall.
`default_nettype none
`include "error_function_approx_defines.svh"

module error_function_approx
  import erfa_pkg::*;
#(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int OUT_WIDTH = OUT_WIDTH_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  erfa_x_if.sink     in_x,
  erfa_erf_if.source out_erf
);

  localparam int XQ_SHIFT  = 32 - IN_WIDTH;
  localparam int SQ_SHIFT  = 64 - 2 * IN_WIDTH;
  localparam int OUT_SHIFT = 33 - OUT_WIDTH;

  localparam logic [35:0] OUT_RND = 36'd1 << (32 - OUT_WIDTH);
  localparam logic [35:0] OUT_SAT = (36'd1 << (OUT_WIDTH - 1)) - 36'd1;

  logic                  adv;
  logic                  push;
  logic                  pop;
  logic [PIPE_LAT-1:0]   vld_r;
  logic [PIPE_LAT-2:0]   neg_r;

  logic [IN_WIDTH-1:0]   in_raw;
  logic                  in_neg;
  logic [IN_WIDTH-1:0]   in_mag;

  logic [IN_WIDTH-1:0]   mag1_r;
  logic [IN_WIDTH+28:0]  pd2_r;
  logic [2*IN_WIDTH-1:0] sq2_r;
  logic [35:0]           sq_w;
  den_t                  den3_r;
  logic [32:0]           sq3_r;
  logic                  big3_r;

  q30_t                  t_div;
  q30_t                  e_w;

  logic [62:0]           hprod_r [1:HORNER_STEPS];
  logic                  hsgn_r  [1:HORNER_STEPS];
  acc_t                  hacc_r  [1:HORNER_STEPS];
  q30_t                  htm_r   [1:HORNER_STEPS-1];
  q30_t                  hta_r   [1:HORNER_STEPS-1];
  acc_t                  pal_r   [ALIGN_LAT];

  logic [31:0]           fin_amag;
  logic [62:0]           fprod_r;
  logic                  fsgn_r;
  logic [32:0]           fin_rnd;
  logic signed [35:0]    fin_prod;
  logic signed [35:0]    fin_y;
  logic [30:0]           fin_yc;
  logic [35:0]           fin_om;
  logic [OUT_WIDTH-1:0]  fin_mag;
  logic [OUT_WIDTH-1:0]  res_r;

  logic [OUT_WIDTH-1:0]  ob_r [2];
  logic [1:0]            cnt_r;

  // Advance while the output buffer has room
  assign adv        = (cnt_r != 2'd2);
  assign in_x.ready = adv;
  assign push       = adv && vld_r[PIPE_LAT-1];
  assign pop        = out_erf.valid && out_erf.ready;

  // Valid bits and sign travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_x.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_r <= {neg_r[PIPE_LAT-3:0], in_neg};
    end
  end

  // Take the magnitude; the most negative input keeps its full size
  assign in_raw = in_x.x_in;
  assign in_neg = in_raw[IN_WIDTH-1];
  assign in_mag = in_neg ? (~in_raw + IN_WIDTH'(1)) : in_raw;

  assign sq_w = 36'(((64'(sq2_r) << SQ_SHIFT) + (64'd1 << 27)) >> 28);

  // Front: magnitude, products, then den in Q.30 and x^2 in Q.28
  always_ff @(posedge clk) begin
    if (adv) begin
      mag1_r <= in_mag;
      pd2_r  <= COEF_P * mag1_r;
      sq2_r  <= mag1_r * mag1_r;
      den3_r <= 32'(64'(ONE_Q30) + (((64'(pd2_r) << XQ_SHIFT) + (64'd1 << 27)) >> 28));
      sq3_r  <= sq_w[32:0];
      big3_r <= |sq_w[35:33];
    end
  end

  erfa_div u_div (
    .clk   (clk),
    .en    (adv),
    .den_i (den3_r),
    .t_o   (t_div)
  );

  erfa_exp u_exp (
    .clk   (clk),
    .en    (adv),
    .sq_i  (sq3_r),
    .big_i (big3_r),
    .e_o   (e_w)
  );

  // Horner evaluation of poly(t) * t, two stages per step
  for (genvar h = 1; h <= HORNER_STEPS; h++) begin : g_horner
    acc_t        acc_in;
    q30_t        t_in;
    logic [31:0] acc_mag;
    logic [32:0] rnd;

    if (h == 1) begin : g_first
      assign acc_in = COEF_A5;
      assign t_in   = t_div;
    end else begin : g_next
      assign acc_in = hacc_r[h-1];
      assign t_in   = hta_r[h-1];
    end

    assign acc_mag = acc_in[32] ? 32'(-acc_in) : 32'(acc_in);
    assign rnd     = 33'((64'(hprod_r[h]) + (64'd1 << 29)) >> 30);

    always_ff @(posedge clk) begin
      if (adv) begin
        hprod_r[h] <= 63'(acc_mag) * 63'(t_in);
        hsgn_r[h]  <= acc_in[32];
        hacc_r[h]  <= (hsgn_r[h] ? -$signed(rnd) : $signed(rnd)) + COEF_ADD[h];
      end
    end

    if (h < HORNER_STEPS) begin : g_tcarry
      always_ff @(posedge clk) begin
        if (adv) begin
          htm_r[h] <= t_in;
          hta_r[h] <= htm_r[h];
        end
      end
    end
  end

  // Delay the polynomial to meet the exp result
  for (genvar a = 0; a < ALIGN_LAT; a++) begin : g_align
    always_ff @(posedge clk) begin
      if (adv) begin
        pal_r[a] <= (a == 0) ? hacc_r[HORNER_STEPS] : pal_r[(a == 0) ? 0 : a - 1];
      end
    end
  end

  // Back: poly * t * exp(-x^2)
  assign fin_amag = pal_r[ALIGN_LAT-1][32] ? 32'(-pal_r[ALIGN_LAT-1])
                                           : 32'(pal_r[ALIGN_LAT-1]);

  always_ff @(posedge clk) begin
    if (adv) begin
      fprod_r <= 63'(fin_amag) * 63'(e_w);
      fsgn_r  <= pal_r[ALIGN_LAT-1][32];
    end
  end

  // Form y = 1 - product, clamp, round to the output format and saturate
  always_comb begin
    fin_rnd  = 33'((64'(fprod_r) + (64'd1 << 29)) >> 30);
    fin_prod = $signed({3'b000, fin_rnd});
    if (fsgn_r) begin
      fin_prod = -fin_prod;
    end
    fin_y = 36'sd1073741824 - fin_prod;
    if (fin_y < 36'sd0) begin
      fin_yc = '0;
    end else if (fin_y > 36'sd1073741824) begin
      fin_yc = ONE_Q30;
    end else begin
      fin_yc = fin_y[30:0];
    end
    fin_om = ({3'b000, fin_yc, 2'b00} + OUT_RND) >> OUT_SHIFT;
    if (fin_om > OUT_SAT) begin
      fin_om = OUT_SAT;
    end
    fin_mag = fin_om[OUT_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= neg_r[PIPE_LAT-2] ? (~fin_mag + OUT_WIDTH'(1)) : fin_mag;
    end
  end

  // Two-entry output buffer, head at entry zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ob_r[0] <= (cnt_r == 2'd2) ? ob_r[1] : res_r;
    end else if (push && cnt_r == 2'd0) begin
      ob_r[0] <= res_r;
    end
    if (push && ((cnt_r == 2'd1 && !pop) || cnt_r == 2'd2)) begin
      ob_r[1] <= res_r;
    end
  end

  assign out_erf.valid   = (cnt_r != 2'd0);
  assign out_erf.erf_out = ob_r[0];

  // Checks
  `EFA_ASSERT_ALWAYS(a_cnt_range, cnt_r != 2'd3)
  `EFA_ASSERT_NEXT(a_stall_holds_valids, !adv, $stable(vld_r))
  `EFA_ASSERT_NEXT(a_push_shows, push, out_erf.valid)
  `EFA_ASSERT_NEXT(a_full_holds, cnt_r == 2'd2 && !out_erf.ready, cnt_r == 2'd2)

endmodule

`default_nettype wire
